[src/msps_pkg.sv]
// ----------------------------------------------------------------------------
// msps_pkg: shared types and constants for the motor speed PID step
// Serial multiplier and divider widths, controller states, register codes.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int MUL_BW     = 17;  // multiplier operand B (serial side)
  localparam int MUL_AW     = 34;  // multiplier operand A
  localparam int ACC_W      = 56;  // product / PID sum accumulator
  localparam int CNT_PROD_W = 28;  // |count| * 6000 fits here
  localparam int REM_W      = 16;  // divider remainder

  localparam int SPEED_SCALE = 6000;
  localparam int ALPHA_Q16   = 3277;
  localparam int TICK_Q16    = 655;
  localparam int INV_TICK    = 100;
  localparam int TERM_LIMIT  = 500;
  localparam int STEP_LIMIT  = 50;
  localparam int GAIN_FRAC   = 8;
  localparam int DUTY_MAX    = 255;
  localparam int SPEED_OUT_MAX = 1048575;

  typedef enum logic [1:0] {
    REG_KP  = 2'd0,
    REG_KI  = 2'd1,
    REG_KD  = 2'd2,
    REG_TGT = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_DIV,
    S_FILT,
    S_ERR,
    S_INTEG,
    S_DER,
    S_P,
    S_I,
    S_D,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic accum;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1)) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

[src/msps_mul.sv]
// ----------------------------------------------------------------------------
// msps_mul: bit-serial signed multiply-accumulate
// Shifts operand B out one bit per cycle; the last bit carries negative weight.
// ----------------------------------------------------------------------------
module msps_mul
  import msps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_ctl_t                 ctl,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [ACC_W-1:0]  acc,
  output unit_stat_t               stat
);

  localparam int CNT_W = $clog2(MUL_BW);

  logic signed [ACC_W-1:0]  a_r, a_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic        [MUL_BW-1:0] b_r, b_nxt;
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start && !busy_r) begin
      a_nxt    = ACC_W'(a);
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      if (!ctl.accum) begin
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      if (b_r[0]) begin
        // sign bit of B weighs -2^(n-1)
        acc_nxt = (cnt_r == CNT_W'(MUL_BW - 1)) ? acc_r - a_r : acc_r + a_r;
      end
      a_nxt   = a_r <<< 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign acc       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[src/msps_div.sv]
// ----------------------------------------------------------------------------
// msps_div: restoring divider by a fixed divisor
// Shifts the dividend in one bit per cycle and forms one quotient bit.
// ----------------------------------------------------------------------------
module msps_div
  import msps_pkg::*;
#(
  parameter int DIVW    = 36,
  parameter int DIVISOR = 330
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  output logic [DIVW-1:0] quot,
  output unit_stat_t      stat
);

  localparam int CNT_W = $clog2(DIVW + 1);

  logic [DIVW-1:0]  q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W:0]   rem_sh;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[DIVW-1]};
    if (start && !busy_r) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= (REM_W+1)'(DIVISOR)) begin
        rem_nxt = REM_W'(rem_sh - (REM_W+1)'(DIVISOR));
        q_nxt   = {q_r[DIVW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[REM_W-1:0];
        q_nxt   = {q_r[DIVW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[src/motor_speed_pid_step.sv]
// ----------------------------------------------------------------------------
// motor_speed_pid_step: one PID speed-control step per encoder count
// Count to rpm, one-pole filter, clamped I and D terms, duty and direction.
// ----------------------------------------------------------------------------
//   channel | ports        | payload (low bit first)
//   --------+--------------+--------------------------------------------------
//   input   | in_t*        | tdata: pulse_count[15:0]
//   result  | out_t*       | tdata: pwm_duty[7:0], forward[8], measured_speed[29:9]
//   config  | cfg_*        | addr: gain_prop, gain_integ, gain_deriv, target_speed
//
// One transaction makes seven passes of the bit-serial multiplier and one pass
// of the bit-serial divider by COUNTS_PER_REV. A new input is taken while a
// finished result still waits in the output register. Reset is synchronous,
// active low, and clears the control state, the configuration, the last target,
// the filter, the integral, the error history and the output valid flag.
// ----------------------------------------------------------------------------
module motor_speed_pid_step
  import msps_pkg::*;
#(
  parameter int COUNTS_PER_REV = 330,
  parameter int FRAC_BITS      = 8
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pulse_count[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pwm_duty[7:0], forward[8], measured_speed[29:9]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int DIVW = CNT_PROD_W + FRAC_BITS;
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(TERM_LIMIT * (2 ** FRAC_BITS));

  state_t state_r, state_nxt;

  logic signed [15:0] kp_r, ki_r, kd_r, tgt_cfg_r;
  logic signed [15:0] tgt_r, tgt_nxt, ltgt_r, ltgt_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] filt_r, filt_nxt, integ_r, integ_nxt, lerr_r, lerr_nxt;
  logic signed [31:0] err_r, err_nxt, deriv_r, deriv_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [31:0]        out_tdata_r, out_tdata_nxt;

  mul_ctl_t                 mul_ctl;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [ACC_W-1:0]  mul_acc;
  unit_stat_t               mul_stat;

  logic            div_start;
  logic [DIVW-1:0] div_dividend, div_quot;
  unit_stat_t      div_stat;

  logic signed [ACC_W-1:0] abs_prod, iter_sum, sum_abs;
  logic [63:0]             mag64;
  logic signed [31:0]      raw, err_c, meas_mag_c;
  logic signed [MUL_AW-1:0] tgt_q;
  logic [32:0]             filt_abs;
  logic [32:0]             meas_sh;
  logic [20:0]             meas21;
  logic [ACC_W-1:0]        duty_sh;
  logic [7:0]              duty;
  logic signed [16:0]      tdiff;
  logic                    in_acc;

  msps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (mul_acc),
    .stat  (mul_stat)
  );

  msps_div #(
    .DIVW    (DIVW),
    .DIVISOR (COUNTS_PER_REV)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // datapath helpers
  always_comb begin
    abs_prod     = mul_acc[ACC_W-1] ? -mul_acc : mul_acc;
    div_dividend = {abs_prod[CNT_PROD_W-1:0], {FRAC_BITS{1'b0}}};
    mag64        = 64'(div_quot);
    if (mag64 >= 64'h8000_0000) begin
      raw = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      raw = neg_r ? -$signed(mag64[31:0]) : $signed(mag64[31:0]);
    end
    tgt_q    = MUL_AW'(tgt_r) <<< FRAC_BITS;
    err_c    = sat32(ACC_W'(tgt_q - MUL_AW'(filt_r)));
    iter_sum = ACC_W'(mul_acc >>> 16);
    sum_abs  = mul_acc[ACC_W-1] ? -mul_acc : mul_acc;
    duty_sh  = sum_abs >> (GAIN_FRAC + FRAC_BITS);
    duty     = (duty_sh > ACC_W'(DUTY_MAX)) ? 8'(DUTY_MAX) : duty_sh[7:0];
    filt_abs = filt_r[31] ? -(33'(filt_r)) : 33'(filt_r);
    meas_sh  = filt_abs >> FRAC_BITS;
    meas_mag_c = (meas_sh > 33'(SPEED_OUT_MAX)) ? 32'(SPEED_OUT_MAX) : 32'(meas_sh);
    meas21   = filt_r[31] ? -meas_mag_c[20:0] : meas_mag_c[20:0];
    tdiff    = 17'(tgt_cfg_r) - 17'(ltgt_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CNT;
      S_CNT:   if (mul_stat.done) state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_FILT;
      S_FILT:  if (mul_stat.done) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_INTEG;
      S_INTEG: if (mul_stat.done) state_nxt = S_DER;
      S_DER:   if (mul_stat.done) state_nxt = S_P;
      S_P:     if (mul_stat.done) state_nxt = S_I;
      S_I:     if (mul_stat.done) state_nxt = S_D;
      S_D:     if (mul_stat.done) state_nxt = S_OUT;
      S_OUT:   if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    mul_ctl        = '0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    tgt_nxt        = tgt_r;
    ltgt_nxt       = ltgt_r;
    neg_nxt        = neg_r;
    filt_nxt       = filt_r;
    integ_nxt      = integ_r;
    lerr_nxt       = lerr_r;
    err_nxt        = err_r;
    deriv_nxt      = deriv_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((ltgt_r > 0 && tgt_cfg_r < 0) || (ltgt_r < 0 && tgt_cfg_r > 0)) begin
            integ_nxt = '0;
            lerr_nxt  = '0;
          end
          if (tdiff > 17'(STEP_LIMIT) || tdiff < -17'(STEP_LIMIT)) begin
            integ_nxt = '0;
          end
          ltgt_nxt    = tgt_cfg_r;
          tgt_nxt     = tgt_cfg_r;
          neg_nxt     = in_tdata[15];
          mul_ctl     = '{start: 1'b1, accum: 1'b0};
          mul_a       = MUL_AW'($signed(in_tdata));
          mul_b       = MUL_BW'(SPEED_SCALE);
        end
      end
      S_CNT: begin
        div_start = mul_stat.done;
      end
      S_DIV: begin
        if (div_stat.done) begin
          mul_ctl = '{start: 1'b1, accum: 1'b0};
          mul_a   = MUL_AW'(raw) - MUL_AW'(filt_r);
          mul_b   = MUL_BW'(ALPHA_Q16);
        end
      end
      S_FILT: begin
        if (mul_stat.done) begin
          filt_nxt = sat32(ACC_W'(filt_r) + iter_sum);
        end
      end
      S_ERR: begin
        err_nxt = err_c;
        mul_ctl = '{start: 1'b1, accum: 1'b0};
        mul_a   = MUL_AW'(err_c);
        mul_b   = MUL_BW'(TICK_Q16);
      end
      S_INTEG: begin
        if (mul_stat.done) begin
          if (ACC_W'(integ_r) + iter_sum > LIM) begin
            integ_nxt = LIM[31:0];
          end else if (ACC_W'(integ_r) + iter_sum < -LIM) begin
            integ_nxt = -LIM[31:0];
          end else begin
            integ_nxt = integ_r + iter_sum[31:0];
          end
          mul_ctl = '{start: 1'b1, accum: 1'b0};
          mul_a   = MUL_AW'(err_r) - MUL_AW'(lerr_r);
          mul_b   = MUL_BW'(INV_TICK);
        end
      end
      S_DER: begin
        if (mul_stat.done) begin
          if (mul_acc > LIM) begin
            deriv_nxt = LIM[31:0];
          end else if (mul_acc < -LIM) begin
            deriv_nxt = -LIM[31:0];
          end else begin
            deriv_nxt = mul_acc[31:0];
          end
          lerr_nxt = err_r;
          mul_ctl  = '{start: 1'b1, accum: 1'b0};
          mul_a    = MUL_AW'(err_r);
          mul_b    = MUL_BW'(kp_r);
        end
      end
      S_P: begin
        if (mul_stat.done) begin
          mul_ctl = '{start: 1'b1, accum: 1'b1};
          mul_a   = MUL_AW'(integ_r);
          mul_b   = MUL_BW'(ki_r);
        end
      end
      S_I: begin
        if (mul_stat.done) begin
          mul_ctl = '{start: 1'b1, accum: 1'b1};
          mul_a   = MUL_AW'(deriv_r);
          mul_b   = MUL_BW'(kd_r);
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, meas21, (tgt_r > 0), (tgt_r == 0) ? 8'd0 : duty};
          // zero target drops the integral and the error history
          if (tgt_r == 0) begin
            integ_nxt = '0;
            lerr_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    deriv_r     <= deriv_nxt;
    tgt_r       <= tgt_nxt;
    neg_r       <= neg_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      tgt_cfg_r    <= '0;
      ltgt_r       <= '0;
      filt_r       <= '0;
      integ_r      <= '0;
      lerr_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ltgt_r       <= ltgt_nxt;
      filt_r       <= filt_nxt;
      integ_r      <= integ_nxt;
      lerr_r       <= lerr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_KP:  kp_r      <= cfg_wdata;
          REG_KI:  ki_r      <= cfg_wdata;
          REG_KD:  kd_r      <= cfg_wdata;
          REG_TGT: tgt_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_stat.busy || div_stat.busy) |-> !in_tready)
    else $error("input ready while an arithmetic unit is busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !mul_stat.busy)
    else $error("multiplier and divider busy together");

  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (ACC_W'(integ_r) <= LIM) && (ACC_W'(integ_r) >= -LIM))
    else $error("integral outside its clamp");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_OUT)
    else $error("result loaded outside the output state");
`endif

endmodule

[tb/motor_speed_pid_step_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_speed_pid_step_checker: result predictor and comparator
// Mirrors config writes, predicts duty, direction and filtered speed for each
// accepted pulse count, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module motor_speed_pid_step_checker
  import msps_pkg::*;
#(
  parameter int COUNTS_PER_REV = 330,
  parameter int FRAC_BITS      = 8
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [20:0] speed;
    logic        fwd;
    logic [7:0]  duty;
  } ctrl_result_t;

  logic signed [15:0] kp, ki, kd, tgt;
  logic signed [31:0] filt_q, integ_q, prev_err_q;
  logic signed [15:0] prev_tgt;
  ctrl_result_t       result_q[$];

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor division by 2^s
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  task automatic predict_step(input logic signed [15:0] count);
    longint lim, mag, raw, v, err, deriv, sum, meas;
    int diff;
    ctrl_result_t r;
    lim = longint'(TERM_LIMIT) <<< FRAC_BITS;
    if ((prev_tgt > 0 && tgt < 0) || (prev_tgt < 0 && tgt > 0)) begin
      integ_q = 0;
      prev_err_q = 0;
    end
    diff = int'(tgt) - int'(prev_tgt);
    if (diff > STEP_LIMIT || diff < -STEP_LIMIT) integ_q = 0;
    prev_tgt = tgt;
    mag = count < 0 ? -longint'(count) : longint'(count);
    mag = ((mag * 6000) <<< FRAC_BITS) / COUNTS_PER_REV;
    raw = mag > 64'sh8000_0000 ? 64'sh8000_0000 : mag;
    if (count < 0) raw = -raw;
    raw = clampl(raw, -64'sh8000_0000, 64'sh7fff_ffff);
    v = longint'(filt_q) + fshift((raw - filt_q) * ALPHA_Q16, 16);
    filt_q = 32'(clampl(v, -64'sh8000_0000, 64'sh7fff_ffff));
    v = longint'(tgt) <<< FRAC_BITS;
    err = clampl(v - filt_q, -64'sh8000_0000, 64'sh7fff_ffff);
    v = longint'(integ_q) + fshift(err * TICK_Q16, 16);
    integ_q = 32'(clampl(v, -lim, lim));
    deriv = clampl((err - prev_err_q) * INV_TICK, -lim, lim);
    prev_err_q = 32'(err);
    sum = longint'(kp) * err + longint'(ki) * integ_q + longint'(kd) * deriv;
    mag = sum < 0 ? -sum : sum;
    mag = mag >>> (GAIN_FRAC + FRAC_BITS);
    if (mag > DUTY_MAX) mag = DUTY_MAX;
    if (tgt == 0) begin
      mag = 0;
      integ_q = 0;
      prev_err_q = 0;
    end
    meas = filt_q < 0 ? -longint'(filt_q) : longint'(filt_q);
    meas = meas >>> FRAC_BITS;
    if (meas > SPEED_OUT_MAX) meas = SPEED_OUT_MAX;
    if (filt_q < 0) meas = -meas;
    r.duty = 8'(mag);
    r.fwd = tgt > 0;
    r.speed = 21'(meas);
    result_q.push_back(r);
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    ctrl_result_t want, got;
    if (!rst_n) begin
      kp <= '0; ki <= '0; kd <= '0; tgt <= '0;
      filt_q = 0; integ_q = 0; prev_err_q = 0; prev_tgt = 0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[29:0];
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = result_q.pop_front();
          if (got !== want || out_tdata[31:30] !== 2'b00) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: duty %0d/%0d fwd %0d/%0d speed %0d/%0d (exp/act)",
                       want.duty, got.duty, want.fwd, got.fwd,
                       $signed(want.speed), $signed(got.speed));
          end
        end
      end
      if (in_tvalid && in_tready) predict_step(in_tdata);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_KP:  kp <= cfg_wdata;
          REG_KI:  ki <= cfg_wdata;
          REG_KD:  kd <= cfg_wdata;
          REG_TGT: tgt <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/motor_speed_pid_step_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_speed_pid_step_tb: regression for the motor speed PID step
// Drives pulse counts under several gain and target settings with random
// flow control on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module motor_speed_pid_step_tb;
  import msps_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 82;
  int          hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  motor_speed_pid_step dut (.*);

  motor_speed_pid_step_checker chk (.*);

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // valid stays up when the task returns; the next send replaces or drops it, drain drops it
  task automatic send_count(input logic [15:0] count);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= count;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(5, 0))
      0: return 16'($urandom);
      1: return $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(120, 0)) - 60);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(3, 0))
      0: return 16'($urandom);
      1: return $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(2048, 0)) - 1024);
    endcase
  endfunction

  function automatic logic [15:0] rand_target();
    case ($urandom_range(3, 0))
      0: return 16'($signed($urandom_range(65534, 0)) - 32767);
      1: return $urandom_range(1, 0) ? 16'sd32767 : -16'sd32767;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(6000, 0)) - 3000);
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [15:0] tgt_now;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero target, count extremes, then gain extremes
    send_count(16'h7fff); send_count(16'h8000); send_count(16'h0000);
    drain();
    write_reg(REG_KP, 16'h0100); write_reg(REG_KI, 16'h0080);
    write_reg(REG_KD, 16'h0010); write_reg(REG_TGT, 16'sd1000);
    send_count(16'd50); send_count(16'd55); send_count(16'h7fff);
    drain();
    write_reg(REG_TGT, 16'sd1030);  // small step keeps integral
    send_count(16'd60); send_count(16'd0);
    drain();
    write_reg(REG_TGT, -16'sd32767);  // sign change and large step
    write_reg(REG_KP, 16'h7fff); write_reg(REG_KI, 16'h8000);
    write_reg(REG_KD, 16'h7fff);
    send_count(16'h8000); send_count(16'h8000); send_count(16'h7fff);
    send_count(16'hffff);
    drain();
    write_reg(REG_TGT, 16'sd32767);
    write_reg(REG_KP, 16'h8000); write_reg(REG_KD, 16'h8000);
    send_count(16'h7fff); send_count(16'h0001);
    drain();
    write_reg(REG_TGT, 16'sd0);
    send_count(16'h1234); send_count(16'h8000);
    drain();

    // random phases: idling profile swaps after the first third, no idling in the last third
    for (int ph = 0; ph < 60; ph++) begin
      if (ph == 20) begin send_idle_pct = 82; recv_idle_pct = 35; end
      if (ph == 40) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_reg(REG_KP, rand_gain());
      write_reg(REG_KI, rand_gain());
      write_reg(REG_KD, rand_gain());
      tgt_now = rand_target();
      write_reg(REG_TGT, tgt_now);
      if (ph == 10 || ph == 45) hold_cycles <= 3000;  // back up the pipeline
      for (int k = 0; k < 28; k++) begin
        if (k == 14 && $urandom_range(3, 0) == 0) begin
          // nudge target within the step limit mid-run
          drain();
          tgt_now = 16'($signed(tgt_now) + $signed($urandom_range(100, 0)) - 50);
          if ($signed(tgt_now) == -32768) tgt_now = 16'sd0;
          write_reg(REG_TGT, tgt_now);
        end
        send_count(rand_count());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
